FILE: design/agf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_pkg
// Shared types and constants for the aging FIFO with per-entry timeout.
// ----------------------------------------------------------------------------
package agf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned AGE_W           = 8;
  localparam int unsigned REQ_W           = 2;

  localparam logic [AGE_W-1:0] LIMIT_RESET = AGE_W'(10);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  // per-cell operation, broadcast to the whole row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_AGE,
    CELL_COMPACT
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [AGE_W-1:0] start_age;
    logic [AGE_W-1:0] tick_amount;
    logic [AGE_W-1:0] limit;
  } cell_ctl_t;

endpackage

FILE: design/aging_fifo_with_timeout_expiry_core.sv
`timescale 1ns / 1ps
// Enqueue, dequeue and other requests: result in the cycle after the start
// transfer, busy stays low, a new request may start every cycle.
// Tick: busy through the compaction sweep of the cell row, one slot per cycle,
// and a final state; the result is registered there and strobed as busy drops.
// Results are strobed for one cycle and cannot be stalled.
// Reset (async, active low) empties the queue and sets the timeout limit to 10.
// ----------------------------------------------------------------------------
// aging_fifo_with_timeout_expiry_core
// FIFO of aging entries held in a row of cells; ticks age all entries and
// squeeze out the expired ones while keeping order.
// ----------------------------------------------------------------------------
module aging_fifo_with_timeout_expiry_core #(
  parameter int unsigned QUEUE_DEPTH = agf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [agf_pkg::REQ_W-1:0]  req_type_i,
  input  logic [agf_pkg::AGE_W-1:0]  start_age_i,
  input  logic [agf_pkg::AGE_W-1:0]  tick_amount_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [agf_pkg::AGE_W-1:0]  cfg_data_i,
  output logic                       result_valid_o,
  output logic                       accepted_o,
  output logic [CNT_W-1:0]           queue_count_o,
  output logic [CNT_W-1:0]           expired_count_o,
  output logic                       head_valid_o,
  output logic [agf_pkg::AGE_W-1:0]  head_age_o
);
  import agf_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(QUEUE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COMPACT = 2'd1;
  localparam logic [1:0] ST_FIN     = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] exp_cnt_q, exp_cnt_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [AGE_W-1:0] limit_q;

  logic             res_vld_q, res_vld_d;
  logic             acc_q, acc_d;
  logic [CNT_W-1:0] qcnt_q, qcnt_d;
  logic [CNT_W-1:0] ecnt_q, ecnt_d;
  logic             hvld_q, hvld_d;
  logic [AGE_W-1:0] hage_q, hage_d;

  cell_ctl_t        ctl;
  logic             issue;

  logic [QUEUE_DEPTH-1:0] vld;
  logic [QUEUE_DEPTH-1:0] expd;
  logic [AGE_W-1:0]       age [QUEUE_DEPTH];

  assign issue       = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             lv, rv, re;
    logic [AGE_W-1:0] ra;
    if (i == 0) begin : g_head
      assign lv = 1'b1;
    end else begin : g_mid
      assign lv = vld[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign ra = '0;
      assign re = 1'b0;
    end else begin : g_body
      assign rv = vld[i+1];
      assign ra = age[i+1];
      assign re = expd[i+1];
    end
    agf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .sel_i       (count_q == CNT_W'(i)),
      .left_vld_i  (lv),
      .right_vld_i (rv),
      .right_age_i (ra),
      .right_exp_i (re),
      .vld_o       (vld[i]),
      .age_o       (age[i]),
      .exp_o       (expd[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    exp_cnt_d = exp_cnt_q;
    step_d    = step_q;
    res_vld_d = 1'b0;
    acc_d     = acc_q;
    qcnt_d    = qcnt_q;
    ecnt_d    = ecnt_q;
    hvld_d    = hvld_q;
    hage_d    = hage_q;

    ctl.op          = CELL_HOLD;
    ctl.start_age   = start_age_i;
    ctl.tick_amount = tick_amount_i;
    ctl.limit       = limit_q;

    unique case (state_q)
      ST_IDLE: begin
        if (issue) begin
          res_vld_d = 1'b1;
          acc_d     = 1'b0;
          ecnt_d    = '0;
          hvld_d    = (count_q != '0);
          hage_d    = (count_q != '0) ? age[0] : '0;
          unique case (req_type_i)
            REQ_ENQUEUE: begin
              if (count_q < FULL) begin
                ctl.op  = CELL_LOAD;
                count_d = count_q + CNT_W'(1);
                acc_d   = 1'b1;
                hvld_d  = 1'b1;
                hage_d  = (count_q == '0) ? start_age_i : age[0];
              end
            end
            REQ_DEQUEUE: begin
              if (count_q != '0) begin
                ctl.op  = CELL_SHIFT;
                count_d = count_q - CNT_W'(1);
                acc_d   = 1'b1;
                hvld_d  = (count_q > CNT_W'(1));
                hage_d  = (count_q > CNT_W'(1)) ? age[1] : '0;
              end
            end
            REQ_TICK: begin
              ctl.op    = CELL_AGE;
              res_vld_d = 1'b0;
              exp_cnt_d = '0;
              step_d    = '0;
              state_d   = ST_COMPACT;
            end
            default: ;
          endcase
          qcnt_d = count_d;
        end
      end
      ST_COMPACT: begin
        ctl.op = CELL_COMPACT;
        // expiry marks stream out of the head slot, one per cycle
        if (expd[0]) begin
          count_d   = count_q - CNT_W'(1);
          exp_cnt_d = exp_cnt_q + CNT_W'(1);
        end
        step_d = step_q + IDX_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_vld_d = 1'b1;
        acc_d     = 1'b0;
        qcnt_d    = count_q;
        ecnt_d    = exp_cnt_q;
        hvld_d    = vld[0];
        hage_d    = vld[0] ? age[0] : '0;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      exp_cnt_q <= '0;
      step_q    <= '0;
      limit_q   <= LIMIT_RESET;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      exp_cnt_q <= exp_cnt_d;
      step_q    <= step_d;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    qcnt_q <= qcnt_d;
    ecnt_q <= ecnt_d;
    hvld_q <= hvld_d;
    hage_q <= hage_d;
  end

  assign result_valid_o  = res_vld_q;
  assign accepted_o      = acc_q;
  assign queue_count_o   = qcnt_q;
  assign expired_count_o = ecnt_q;
  assign head_valid_o    = hvld_q;
  assign head_age_o      = hage_q;

endmodule

FILE: design/agf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_cell
// One queue slot: holds an age, an occupied flag and an expiry mark, and
// exchanges them with its right neighbor.
// ----------------------------------------------------------------------------
module agf_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  agf_pkg::cell_ctl_t       ctl_i,
  input  logic                     sel_i,
  input  logic                     left_vld_i,
  input  logic                     right_vld_i,
  input  logic [agf_pkg::AGE_W-1:0] right_age_i,
  input  logic                     right_exp_i,
  output logic                     vld_o,
  output logic [agf_pkg::AGE_W-1:0] age_o,
  output logic                     exp_o
);
  import agf_pkg::*;

  logic             vld_q, vld_d;
  logic             exp_q, exp_d;
  logic [AGE_W-1:0] age_q, age_d;
  logic [AGE_W:0]   sum;
  logic [AGE_W-1:0] sat;

  assign sum = {1'b0, age_q} + {1'b0, ctl_i.tick_amount};
  assign sat = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];

  always_comb begin
    vld_d = vld_q;
    age_d = age_q;
    exp_d = exp_q;
    case (ctl_i.op)
      CELL_LOAD: begin
        if (sel_i) begin
          vld_d = 1'b1;
          age_d = ctl_i.start_age;
        end
      end
      CELL_SHIFT: begin
        vld_d = right_vld_i;
        age_d = right_age_i;
      end
      CELL_AGE: begin
        exp_d = 1'b0;
        if (vld_q) begin
          if (sat >= ctl_i.limit) begin
            vld_d = 1'b0;
            exp_d = 1'b1;
          end else begin
            age_d = sat;
          end
        end
      end
      CELL_COMPACT: begin
        // holes bubble toward the tail; an entry moves left into an empty slot
        exp_d = right_exp_i;
        if (!vld_q) begin
          vld_d = right_vld_i;
          age_d = right_age_i;
        end else if (!left_vld_i) begin
          vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      exp_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      exp_q <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q <= age_d;
  end

  assign vld_o = vld_q;
  assign age_o = age_q;
  assign exp_o = exp_q;

endmodule

FILE: design/agf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agf_checker
// Port-level checks on the aging FIFO core, attached by bind.
// ----------------------------------------------------------------------------
module agf_checker #(
  parameter int unsigned QUEUE_DEPTH = agf_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [agf_pkg::REQ_W-1:0] req_type_i,
  input logic                      result_valid_o,
  input logic                      accepted_o,
  input logic [CNT_W-1:0]          queue_count_o,
  input logic [CNT_W-1:0]          expired_count_o,
  input logic                      head_valid_o,
  input logic [agf_pkg::AGE_W-1:0] head_age_o
);
  import agf_pkg::*;

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (head_valid_o == (queue_count_o != '0)))
    else $error("head_valid disagrees with queue_count");

  a_empty_head_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !head_valid_o) |-> (head_age_o == '0))
    else $error("empty queue reports nonzero head age");

  a_tick_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_TICK) |=> (busy && !result_valid_o))
    else $error("tick transfer did not start compaction");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i != REQ_TICK) |=> (result_valid_o && !busy))
    else $error("missing result after queue request");

  a_no_expiry_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && accepted_o) |-> (expired_count_o == '0))
    else $error("expired count on an accepted request");

endmodule

bind aging_fifo_with_timeout_expiry_core agf_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH),
  .CNT_W      (CNT_W)
) u_agf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_type_i     (req_type_i),
  .result_valid_o (result_valid_o),
  .accepted_o     (accepted_o),
  .queue_count_o  (queue_count_o),
  .expired_count_o(expired_count_o),
  .head_valid_o   (head_valid_o),
  .head_age_o     (head_age_o)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the aging FIFO with per-entry timeout. A clocked
// driver feeds enqueue, dequeue, tick and unused requests from a plan queue.
// It also writes the timeout limit between phases, when the queue is idle.
// A clocked monitor checks every strobed status against an in-bench model
// of the queue, field by field.
// ----------------------------------------------------------------------------
module testbench;

  import agf_pkg::*;

  localparam int unsigned QDEPTH         = QUEUE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = QDEPTH + 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 92;

  // request code with no defined operation
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STEP_REQUEST,
    STEP_LIMIT_WRITE,
    STEP_WAIT_EMPTY,
    STEP_IDLE_MODE
  } step_kind_e;

  typedef struct {
    step_kind_e       kind;
    logic [REQ_W-1:0] req;
    logic [AGE_W-1:0] age;
    logic [AGE_W-1:0] amount;
    int unsigned      value;   // limit or idle percentage
  } plan_step_t;

  typedef struct packed {
    logic             accepted;
    logic [4:0]       count;
    logic [4:0]       expired;
    logic             head_valid;
    logic [AGE_W-1:0] head_age;
  } queue_status_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start         = 1'b0;
  logic             busy;
  logic [REQ_W-1:0] req_type_i    = '0;
  logic [AGE_W-1:0] start_age_i   = '0;
  logic [AGE_W-1:0] tick_amount_i = '0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [AGE_W-1:0] cfg_data_i    = '0;
  logic             result_valid_o;
  logic             accepted_o;
  logic [4:0]       queue_count_o;
  logic [4:0]       expired_count_o;
  logic             head_valid_o;
  logic [AGE_W-1:0] head_age_o;

  aging_fifo_with_timeout_expiry_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .start_age_i    (start_age_i),
    .tick_amount_i  (tick_amount_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .accepted_o     (accepted_o),
    .queue_count_o  (queue_count_o),
    .expired_count_o(expired_count_o),
    .head_valid_o   (head_valid_o),
    .head_age_o     (head_age_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---- queue model --------------------------------------------------------
  logic [AGE_W-1:0] fifo_ages [QDEPTH];
  int unsigned      fifo_count  = 0;
  logic [AGE_W-1:0] timeout_lim = LIMIT_RESET;

  queue_status_t queue_status_q[$];
  plan_step_t    request_plan_q[$];

  int unsigned n_enqueued     = 0;
  int unsigned n_dequeued     = 0;
  int unsigned n_ticks        = 0;
  int unsigned n_unused_reqs  = 0;
  int unsigned n_full_rejects = 0;
  int unsigned n_empty_pops   = 0;
  int unsigned n_aged_out     = 0;
  int unsigned n_limit_writes = 0;
  int unsigned n_checked      = 0;
  int unsigned fails          = 0;

  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [AGE_W-1:0] age_in,
                               input logic [AGE_W-1:0] amount);
    queue_status_t st;
    int unsigned   kept;
    int unsigned   aged;
    st = '0;
    case (req)
      REQ_ENQUEUE: begin
        if (fifo_count < QDEPTH) begin
          fifo_ages[fifo_count] = age_in;
          fifo_count++;
          st.accepted = 1'b1;
          n_enqueued++;
        end else begin
          n_full_rejects++;
        end
      end
      REQ_DEQUEUE: begin
        if (fifo_count > 0) begin
          for (int i = 1; i < fifo_count; i++) fifo_ages[i-1] = fifo_ages[i];
          fifo_count--;
          st.accepted = 1'b1;
          n_dequeued++;
        end else begin
          n_empty_pops++;
        end
      end
      REQ_TICK: begin
        kept = 0;
        for (int i = 0; i < fifo_count; i++) begin
          aged = 32'(fifo_ages[i]) + 32'(amount);
          if (aged > 255) aged = 255;
          if (aged >= 32'(timeout_lim)) begin
            st.expired++;
          end else begin
            fifo_ages[kept] = 8'(aged);
            kept++;
          end
        end
        fifo_count = kept;
        n_aged_out += 32'(st.expired);
        n_ticks++;
      end
      default: n_unused_reqs++;
    endcase
    st.count      = 5'(fifo_count);
    st.head_valid = (fifo_count > 0);
    st.head_age   = (fifo_count > 0) ? fifo_ages[0] : '0;
    queue_status_q.push_back(st);
  endtask

  // ---- plan building ------------------------------------------------------
  function automatic void plan_request(input logic [REQ_W-1:0] req,
                                       input logic [AGE_W-1:0] age,
                                       input logic [AGE_W-1:0] amount);
    plan_step_t s;
    s = '{kind: STEP_REQUEST, req: req, age: age, amount: amount, value: 0};
    request_plan_q.push_back(s);
  endfunction

  function automatic void plan_control(input step_kind_e kind, input int unsigned value);
    plan_step_t s;
    s = '{kind: kind, req: '0, age: '0, amount: '0, value: value};
    request_plan_q.push_back(s);
  endfunction

  // limit writes only go out once the queue has gone quiet
  function automatic void plan_limit(input int unsigned lim);
    plan_control(STEP_WAIT_EMPTY, 0);
    plan_control(STEP_LIMIT_WRITE, lim);
  endfunction

  // mostly ages below the limit and small ticks, so entries live long enough
  // to fill the queue; some fully random values for the rest
  function automatic void plan_random(input int unsigned lim);
    int unsigned      r;
    logic [REQ_W-1:0] req;
    logic [AGE_W-1:0] age;
    logic [AGE_W-1:0] amount;
    r = $urandom_range(99);
    if (r < 45) req = REQ_ENQUEUE;
    else if (r < 70) req = REQ_DEQUEUE;
    else if (r < 95) req = REQ_TICK;
    else req = REQ_UNUSED;
    if ($urandom_range(4) == 0) age = AGE_W'($urandom);
    else age = AGE_W'($urandom_range(0, (lim > 1) ? lim - 1 : 0));
    if ($urandom_range(4) == 0) amount = AGE_W'($urandom);
    else amount = AGE_W'($urandom_range(0, lim / 8 + 1));
    plan_request(req, age, amount);
  endfunction

  // ---- driver -------------------------------------------------------------
  int unsigned idle_pct = 0;
  int unsigned settle   = 0;
  bit          have_cur = 1'b0;
  bit          draining = 1'b0;

  always @(posedge clk_i) begin : drive_proc
    plan_step_t       cur;
    logic             n_start;
    logic             n_cfg_valid;
    logic [REQ_W-1:0] n_req;
    logic [AGE_W-1:0] n_age;
    logic [AGE_W-1:0] n_amt;
    logic [AGE_W-1:0] n_cfg;
    n_start     = start;
    n_cfg_valid = cfg_valid_i;
    n_req       = req_type_i;
    n_age       = start_age_i;
    n_amt       = tick_amount_i;
    n_cfg       = cfg_data_i;
    if (rst_ni) begin
      if (start && !busy) begin
        apply_request(req_type_i, start_age_i, tick_amount_i);
        n_start  = 1'b0;
        have_cur = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_lim = cfg_data_i;
        n_limit_writes++;
        n_cfg_valid = 1'b0;
        have_cur    = 1'b0;
      end
      if (!have_cur) begin
        if (draining && queue_status_q.size() == 0) begin
          if (settle > 0) settle--;
          else draining = 1'b0;
        end
        if (!draining && request_plan_q.size() > 0) begin
          cur = request_plan_q[0];
          case (cur.kind)
            STEP_IDLE_MODE: begin
              idle_pct = cur.value;
              void'(request_plan_q.pop_front());
            end
            STEP_WAIT_EMPTY: begin
              draining = 1'b1;
              settle   = SETTLE_CYCLES;
              void'(request_plan_q.pop_front());
            end
            STEP_LIMIT_WRITE: begin
              n_cfg_valid = 1'b1;
              n_cfg       = 8'(cur.value);
              have_cur    = 1'b1;
              void'(request_plan_q.pop_front());
            end
            default: begin
              if ($urandom_range(99) >= idle_pct) begin
                n_start  = 1'b1;
                n_req    = cur.req;
                n_age    = cur.age;
                n_amt    = cur.amount;
                have_cur = 1'b1;
                void'(request_plan_q.pop_front());
              end
            end
          endcase
        end
      end
      // junk on the fields while nothing is offered
      if (!n_start) begin
        n_req = REQ_W'($urandom);
        n_age = AGE_W'($urandom);
        n_amt = AGE_W'($urandom);
      end
      if (!n_cfg_valid) n_cfg = AGE_W'($urandom);
    end
    start         <= n_start;
    req_type_i    <= n_req;
    start_age_i   <= n_age;
    tick_amount_i <= n_amt;
    cfg_valid_i   <= n_cfg_valid;
    cfg_data_i    <= n_cfg;
  end

  // ---- monitor and watchdog -----------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : monitor_proc
    queue_status_t want;
    if (rst_ni) begin
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
      if (result_valid_o) begin
        n_checked++;
        if (queue_status_q.size() == 0) begin
          $error("status strobed with no request outstanding");
          fails++;
        end else begin
          want = queue_status_q.pop_front();
          if (accepted_o !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, accepted_o);
            fails++;
          end
          if (queue_count_o !== want.count) begin
            $error("queue_count: expected %0d, got %0d", want.count, queue_count_o);
            fails++;
          end
          if (expired_count_o !== want.expired) begin
            $error("expired_count: expected %0d, got %0d", want.expired, expired_count_o);
            fails++;
          end
          if (head_valid_o !== want.head_valid) begin
            $error("head_valid: expected %0d, got %0d", want.head_valid, head_valid_o);
            fails++;
          end
          if (head_age_o !== want.head_age) begin
            $error("head_age: expected %0d, got %0d", want.head_age, head_age_o);
            fails++;
          end
        end
      end
    end
  end

  // ---- plan, reset and end of run -----------------------------------------
  initial begin : main_proc
    int unsigned phase_limits [NUM_PHASES];
    int unsigned phase_idle [4];
    phase_limits = '{1, 255, 10, 0, 0, 128, 0, 255};
    phase_limits[3] = $urandom_range(2, 254);
    phase_limits[6] = $urandom_range(1, 255);
    phase_idle   = '{0, 68, 0, 32};

    // directed part, reset limit of 10
    plan_control(STEP_IDLE_MODE, 0);
    plan_request(REQ_TICK, 8'd0, 8'd0);        // tick on empty queue
    plan_request(REQ_DEQUEUE, 8'd0, 8'd0);     // pop from empty queue
    plan_request(REQ_UNUSED, 8'd0, 8'd0);
    plan_request(REQ_ENQUEUE, 8'd0, 8'd0);
    plan_request(REQ_ENQUEUE, 8'd255, 8'd0);   // already past the limit
    plan_request(REQ_ENQUEUE, 8'd5, 8'd0);
    plan_request(REQ_ENQUEUE, 8'd9, 8'd0);
    plan_request(REQ_UNUSED, 8'hff, 8'hff);
    plan_request(REQ_TICK, 8'hff, 8'd0);       // zero tick still drops the stale one
    plan_request(REQ_TICK, 8'd0, 8'd1);        // 9 reaches the limit
    plan_request(REQ_DEQUEUE, 8'd0, 8'd0);
    for (int i = 0; i < QDEPTH; i++) plan_request(REQ_ENQUEUE, 8'(i % 10), 8'd0);
    plan_request(REQ_ENQUEUE, 8'd3, 8'd0);     // full, dropped
    plan_request(REQ_TICK, 8'd0, 8'd255);      // everything goes at once

    plan_limit(255);
    plan_request(REQ_ENQUEUE, 8'd250, 8'd0);
    plan_request(REQ_ENQUEUE, 8'd0, 8'd0);
    plan_request(REQ_TICK, 8'd0, 8'd200);      // first saturates, second survives
    plan_request(REQ_TICK, 8'd0, 8'd0);
    plan_request(REQ_DEQUEUE, 8'd0, 8'd0);
    plan_limit(0);
    plan_request(REQ_ENQUEUE, 8'd0, 8'd0);
    plan_request(REQ_ENQUEUE, 8'd0, 8'd0);
    plan_request(REQ_TICK, 8'd0, 8'd0);        // zero limit drops all

    // random phases, limit written while idle at each boundary
    for (int p = 0; p < NUM_PHASES; p++) begin
      plan_limit(phase_limits[p]);
      plan_control(STEP_IDLE_MODE, phase_idle[p % 4]);
      for (int k = 0; k < PHASE_ITEMS; k++) plan_random(phase_limits[p]);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_plan_q.size() != 0 || have_cur || draining || queue_status_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (queue_status_q.size() != 0) begin
      $error("%0d status results never arrived", queue_status_q.size());
      fails++;
    end
    $display("Covered %0d enqueues, %0d dequeues, %0d ticks, %0d unused codes; %0d checked",
             n_enqueued, n_dequeued, n_ticks, n_unused_reqs, n_checked);
    $display("Full drops %0d, empty pops %0d, aged out %0d, limit writes %0d",
             n_full_rejects, n_empty_pops, n_aged_out, n_limit_writes);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
